[hdl/drc_pkg.sv]
package drc_pkg;

  // Configuration constants
  localparam int unsigned DEPTH_BITS = 8;   // call-depth counter width, 4..16
  localparam int unsigned CYCLE_BITS = 48;  // significant bits of the cycle counter, 32..64

  // Fixed field widths
  localparam int unsigned PC_W    = 16;
  localparam int unsigned OP_W    = 8;
  localparam int unsigned CYC_W   = 48;

  localparam logic [OP_W-1:0] OP_CALL   = 8'h20;
  localparam logic [OP_W-1:0] OP_RETURN = 8'h60;
  localparam logic [PC_W-1:0] CALL_LEN  = 16'd3;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  localparam logic [CYC_W-1:0] CYCLE_MASK = (CYCLE_BITS >= CYC_W) ? {CYC_W{1'b1}} :
      CYC_W'((65'(1) << CYCLE_BITS) - 65'(1));

  typedef enum logic [3:0] {
    FUNC_CHECK     = 4'd0,
    FUNC_PAUSE     = 4'd1,
    FUNC_RUN       = 4'd2,
    FUNC_RUN_TO    = 4'd3,
    FUNC_STEP      = 4'd4,
    FUNC_STEP_OUT  = 4'd5,
    FUNC_STEP_OVER = 4'd6,
    FUNC_STOP      = 4'd7,
    FUNC_RESET     = 4'd8
  } func_e;

  typedef enum logic [3:0] {
    ACT_STOP      = 4'd0,
    ACT_FAST      = 4'd1,
    ACT_RESTORE   = 4'd2,
    ACT_SLOW      = 4'd3,
    ACT_SWAP      = 4'd4,
    ACT_TRACE_OFF = 4'd5,
    ACT_TRACE_ON  = 4'd6,
    ACT_TYPE      = 4'd7,
    ACT_NONE      = 4'd8
  } bp_action_e;

  typedef enum logic [1:0] {
    SPEED_CONFIG = 2'd0,
    SPEED_MAX    = 2'd1,
    SPEED_NORMAL = 2'd2
  } speed_e;

  typedef enum logic [2:0] {
    SIDE_NONE      = 3'd0,
    SIDE_SWAP      = 3'd1,
    SIDE_TRACE_OFF = 3'd2,
    SIDE_TRACE_ON  = 3'd3,
    SIDE_TYPE      = 3'd4
  } side_e;

  typedef struct packed {
    logic [3:0]       func;
    logic [PC_W-1:0]  pc;
    logic [OP_W-1:0]  opcode;
    logic             bp_hit;
    logic [3:0]       bp_action;
    logic [CYC_W-1:0] cycle_count;
  } drc_in_t;

  typedef struct packed {
    logic             proceed;
    logic             running;
    logic [1:0]       speed_mode;
    logic [2:0]       side_action;
    logic [CYC_W-1:0] stop_cycle;
    logic [CYC_W-1:0] prev_stop_cycle;
  } drc_out_t;

endpackage

[hdl/debug_run_control_top.sv]
// Debug run control for an 8-bit processor core.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
// debugger command (pause, run, run to pc, step, step out, step over, stop,
// reset-run) or per instruction check from the core. Every input beat yields
// exactly one result beat on the output channel (out_valid_o / out_ready_i /
// out_data_o): proceed tells the core whether to execute the instruction,
// together with the run flag, speed mode, side action and the cycle counts
// latched at the last two halts.
//
// The input register feeds the decision logic, which updates the run state and
// loads the result register. Throughput is one beat per cycle while the
// receiver does not stall; the state update is the only loop.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; after that in_ready_o drops until the result
// drains. Reset empties both registers and sets the run flag, with all step
// modes, the target pc, call depth, speed mode and stop latches cleared.
module debug_run_control_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  drc_pkg::drc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drc_pkg::drc_out_t out_data_o
);
  import drc_pkg::*;

  // Input stage
  logic    s1_valid_q;
  drc_in_t s1_q;
  logic    advance;

  // Run state
  logic                  run_q, run_d;
  logic                  step_q, step_d;
  logic                  step_out_q, step_out_d;
  logic                  run_to_q, run_to_d;
  logic [PC_W-1:0]       target_q, target_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  speed_e                speed_q, speed_d;
  logic [CYC_W-1:0]      last_stop_q, last_stop_d;
  logic [CYC_W-1:0]      early_stop_q, early_stop_d;

  // Result stage
  logic     out_valid_q;
  drc_out_t out_q, out_d;
  logic     proceed;
  side_e    side;

  // Move a beat into the result register when it is empty or being drained.
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
  end

  // Decision logic: one command or one instruction check per beat.
  always_comb begin
    run_d        = run_q;
    step_d       = step_q;
    step_out_d   = step_out_q;
    run_to_d     = run_to_q;
    target_d     = target_q;
    depth_d      = depth_q;
    speed_d      = speed_q;
    last_stop_d  = last_stop_q;
    early_stop_d = early_stop_q;
    proceed      = 1'b0;
    side         = SIDE_NONE;

    unique case (s1_q.func)
      FUNC_CHECK: begin
        if (run_q) begin
          if (step_q) begin
            if (!run_to_q) begin
              // Plain single step: halt after this instruction, no latch.
              run_d      = 1'b0;
              step_d     = 1'b0;
              step_out_d = 1'b0;
              run_to_d   = 1'b0;
              target_d   = '0;
              depth_d    = '0;
            end else begin
              // Step over a call: drop the step, run on to the target.
              step_d = 1'b0;
            end
            proceed = 1'b1;
          end else if (!run_to_q && step_out_q && s1_q.opcode == OP_RETURN &&
                       depth_q == '0) begin
            // Return out of the stepped routine: execute it, then halt.
            run_d      = 1'b0;
            step_out_d = 1'b0;
            target_d   = '0;
            depth_d    = '0;
            proceed    = 1'b1;
          end else if (run_to_q && target_q != s1_q.pc && step_out_q &&
                       s1_q.opcode == OP_RETURN && depth_q == '0) begin
            run_d      = 1'b0;
            step_out_d = 1'b0;
            run_to_d   = 1'b0;
            target_d   = '0;
            depth_d    = '0;
            proceed    = 1'b1;
          end else begin
            if (run_to_q && target_q == s1_q.pc) begin
              run_d      = 1'b0;
              step_out_d = 1'b0;
              run_to_d   = 1'b0;
              target_d   = '0;
              depth_d    = '0;
            end else if (step_out_q) begin
              if (s1_q.opcode == OP_CALL) begin
                if (depth_q != DEPTH_MAX) begin
                  depth_d = depth_q + 1'b1;
                end
              end else if (s1_q.opcode == OP_RETURN) begin
                depth_d = depth_q - 1'b1;
              end
            end
            if (s1_q.bp_hit) begin
              unique case (s1_q.bp_action)
                ACT_STOP: begin
                  run_d      = 1'b0;
                  step_out_d = 1'b0;
                  run_to_d   = 1'b0;
                  target_d   = '0;
                  depth_d    = '0;
                end
                ACT_FAST:      speed_d = SPEED_MAX;
                ACT_RESTORE:   speed_d = SPEED_CONFIG;
                ACT_SLOW:      speed_d = SPEED_NORMAL;
                ACT_SWAP:      side    = SIDE_SWAP;
                ACT_TRACE_OFF: side    = SIDE_TRACE_OFF;
                ACT_TRACE_ON:  side    = SIDE_TRACE_ON;
                ACT_TYPE:      side    = SIDE_TYPE;
                default: ;
              endcase
            end
            proceed = run_d;
            // Latch the halt time.
            if (!run_d) begin
              early_stop_d = last_stop_q;
              last_stop_d  = s1_q.cycle_count & CYCLE_MASK;
            end
          end
        end
      end
      FUNC_PAUSE: run_d = 1'b0;
      FUNC_RUN:   run_d = 1'b1;
      FUNC_RUN_TO: begin
        run_d    = 1'b1;
        run_to_d = 1'b1;
        target_d = s1_q.pc;
      end
      FUNC_STEP: begin
        run_d  = 1'b1;
        step_d = 1'b1;
      end
      FUNC_STEP_OUT: begin
        run_d      = 1'b1;
        depth_d    = '0;
        step_out_d = 1'b1;
      end
      FUNC_STEP_OVER: begin
        if (s1_q.opcode == OP_CALL) begin
          target_d = s1_q.pc + CALL_LEN;
          run_to_d = 1'b1;
        end
        step_d = 1'b1;
        run_d  = 1'b1;
      end
      FUNC_STOP: begin
        run_d      = 1'b0;
        step_d     = 1'b0;
        step_out_d = 1'b0;
        run_to_d   = 1'b0;
        target_d   = '0;
        depth_d    = '0;
      end
      FUNC_RESET: begin
        run_d    = 1'b1;
        run_to_d = 1'b0;
      end
      default: ;  // unused command codes leave everything alone
    endcase

    out_d.proceed         = proceed;
    out_d.running         = run_d;
    out_d.speed_mode      = speed_d;
    out_d.side_action     = side;
    out_d.stop_cycle      = last_stop_d;
    out_d.prev_stop_cycle = early_stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= 1'b1;
      step_q       <= 1'b0;
      step_out_q   <= 1'b0;
      run_to_q     <= 1'b0;
      target_q     <= '0;
      depth_q      <= '0;
      speed_q      <= SPEED_CONFIG;
      last_stop_q  <= '0;
      early_stop_q <= '0;
    end else if (advance) begin
      run_q        <= run_d;
      step_q       <= step_d;
      step_out_q   <= step_out_d;
      run_to_q     <= run_to_d;
      target_q     <= target_d;
      depth_q      <= depth_d;
      speed_q      <= speed_d;
      last_stop_q  <= last_stop_d;
      early_stop_q <= early_stop_d;
    end
  end

  // Result register: load on advance, drop once the receiver takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/drc_checker.sv]
module drc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input drc_pkg::drc_out_t out_data_i
);
  import drc_pkg::*;

  logic             out_beat;
  logic             run_seen_q;
  logic [CYC_W-1:0] stop_seen_q;

  assign out_beat = out_valid_i && out_ready_i;

  // Track the run flag and stop latch as reported by the previous result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_seen_q  <= 1'b1;
      stop_seen_q <= '0;
    end else if (out_beat) begin
      run_seen_q  <= out_data_i.running;
      stop_seen_q <= out_data_i.stop_cycle;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_halted_no_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && (out_data_i.proceed || out_data_i.side_action != SIDE_NONE)
      |-> run_seen_q)
    else $error("instruction released or action signalled while halted");

  a_run_no_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_i.running |-> out_data_i.stop_cycle == stop_seen_q)
    else $error("stop cycle latched without a halt");

  a_latch_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_i.stop_cycle != stop_seen_q
      |-> out_data_i.prev_stop_cycle == stop_seen_q)
    else $error("previous stop cycle not shifted from last stop");

endmodule

bind debug_run_control_top drc_checker u_drc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
